/* src/spht_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sparse pair histogram table - shared definitions
// Word types, operation and status codes, sequencer states and sizing
// constants for the pair histogram table and its storage.
// ----------------------------------------------------------------------------
package spht_pkg;

    localparam int unsigned CAPACITY_DEF = 1024;
    localparam int unsigned ID_W         = 16;
    localparam int unsigned VAL_W        = 32;
    localparam int unsigned IDX_W        = 10;
    localparam int unsigned CNT_W        = 11;
    localparam int unsigned KEY_W        = 2 * ID_W;

    typedef enum logic [1:0] {
        OP_ACCUM     = 2'd0,
        OP_LOOKUP    = 2'd1,
        OP_READ_IDX  = 2'd2,
        OP_WRITE_IDX = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_SAT   = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CHECK,
        S_MISS,
        S_DONE
    } t_state;

    typedef struct packed {
        t_op                      operation;
        logic [ID_W-1:0]          detector_a;
        logic [ID_W-1:0]          detector_b;
        logic [IDX_W-1:0]         entry_index;
        logic signed [VAL_W-1:0]  value;
    } t_in_word;

    typedef struct packed {
        logic signed [VAL_W-1:0]  result_value;
        logic [ID_W-1:0]          pair_low;
        logic [ID_W-1:0]          pair_high;
        logic                     found;
        t_status                  status;
        logic [CNT_W-1:0]         entry_count;
    } t_out_word;

endpackage
`default_nettype wire

/* src/spht_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module spht_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

/* src/sparse_pair_histogram_table.sv */
`timescale 1ns / 1ps
`default_nettype none
// Accumulate and lookup scan the entries in insertion order, each entry a read of both
// stores (S_READ) and then a key compare (S_CHECK): a hit goes on to S_DONE, a miss to
// S_MISS and then S_DONE, and an empty table goes straight to S_MISS. Read and write by
// index pass S_READ, S_CHECK and S_DONE; an index beyond the count goes straight to S_DONE.
// One word is in work at a time; the next word is taken once the result sits in the output register.
// Synchronous reset empties the table (count 0); the stores themselves are not cleared.
// ----------------------------------------------------------------------------
// Sparse pair histogram table
// Insertion-ordered table of canonical detector pairs with saturating Q16.16
// values, searched by a shared compare unit under a small sequencer.
// ----------------------------------------------------------------------------
module sparse_pair_histogram_table #(
    parameter int unsigned CAPACITY = spht_pkg::CAPACITY_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire spht_pkg::t_in_word  i_in_word,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output spht_pkg::t_out_word      o_out_word
);

    import spht_pkg::*;

    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned XW = (CW > IDX_W) ? CW : IDX_W;

    // control state
    t_state              r_state, n_state;
    logic [CW-1:0]       r_used, n_used;
    logic                r_out_valid, n_out_valid;

    // payload
    t_op                 r_op, n_op;
    logic [KEY_W-1:0]    r_key, n_key;
    logic [AW-1:0]       r_idx, n_idx;
    logic [VAL_W-1:0]    r_val, n_val;
    t_out_word           r_res, n_res;
    t_out_word           r_out_word, n_out_word;

    // store ports
    logic [AW-1:0]       ram_raddr;
    logic [AW-1:0]       ram_waddr;
    logic                pair_we;
    logic                value_we;
    logic [KEY_W-1:0]    pair_wdata;
    logic [VAL_W-1:0]    value_wdata;
    logic [KEY_W-1:0]    pair_rdata;
    logic [VAL_W-1:0]    value_rdata;

    logic [ID_W-1:0]     in_lo;
    logic [ID_W-1:0]     in_hi;
    logic [VAL_W:0]      sum_x;
    logic                sum_ovf;
    logic [VAL_W-1:0]    sum_sat;

    spht_ram #(
        .WIDTH (KEY_W),
        .DEPTH (CAPACITY)
    ) u_pair_ram (
        .i_clk   (i_clk),
        .i_we    (pair_we),
        .i_waddr (ram_waddr),
        .i_wdata (pair_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (pair_rdata)
    );

    spht_ram #(
        .WIDTH (VAL_W),
        .DEPTH (CAPACITY)
    ) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (value_we),
        .i_waddr (ram_waddr),
        .i_wdata (value_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (value_rdata)
    );

    // canonical pair: smaller id low
    assign in_lo = (i_in_word.detector_a < i_in_word.detector_b) ?
                   i_in_word.detector_a : i_in_word.detector_b;
    assign in_hi = (i_in_word.detector_a < i_in_word.detector_b) ?
                   i_in_word.detector_b : i_in_word.detector_a;

    // saturating add, clamp on sign disagreement of the extended sum
    assign sum_x   = {value_rdata[VAL_W-1], value_rdata} + {r_val[VAL_W-1], r_val};
    assign sum_ovf = sum_x[VAL_W] ^ sum_x[VAL_W-1];
    assign sum_sat = !sum_ovf ? sum_x[VAL_W-1:0] :
                     (sum_x[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}});

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    always_comb begin
        n_state     = r_state;
        n_used      = r_used;
        n_out_valid = r_out_valid && i_out_stall;
        n_op        = r_op;
        n_key       = r_key;
        n_idx       = r_idx;
        n_val       = r_val;
        n_res       = r_res;
        n_out_word  = r_out_word;
        ram_raddr   = r_idx;
        ram_waddr   = r_idx;
        pair_we     = 1'b0;
        value_we    = 1'b0;
        pair_wdata  = r_key;
        value_wdata = r_val;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op               = i_in_word.operation;
                    n_key              = {in_hi, in_lo};
                    n_val              = i_in_word.value;
                    n_idx              = '0;
                    n_res              = '0;
                    n_res.pair_low     = in_lo;
                    n_res.pair_high    = in_hi;
                    n_res.status       = ST_OK;
                    if (i_in_word.operation inside {OP_ACCUM, OP_LOOKUP}) begin
                        n_state = (r_used == '0) ? S_MISS : S_READ;
                    end else if (XW'(i_in_word.entry_index) < XW'(r_used)) begin
                        n_idx   = AW'(i_in_word.entry_index);
                        n_state = S_READ;
                    end else begin
                        n_res.pair_low  = '0;
                        n_res.pair_high = '0;
                        n_res.status    = ST_RANGE;
                        n_state         = S_DONE;
                    end
                end
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (r_op inside {OP_ACCUM, OP_LOOKUP}) begin
                    if (pair_rdata == r_key) begin
                        n_res.found = 1'b1;
                        if (r_op == OP_ACCUM) begin
                            value_we           = 1'b1;
                            value_wdata        = sum_sat;
                            n_res.result_value = sum_sat;
                            if (sum_ovf) begin
                                n_res.status = ST_SAT;
                            end
                        end else begin
                            n_res.result_value = value_rdata;
                        end
                        n_state = S_DONE;
                    end else if (CW'(r_idx) + CW'(1) == r_used) begin
                        n_state = S_MISS;
                    end else begin
                        // advance to the next entry
                        n_idx   = r_idx + AW'(1);
                        n_state = S_READ;
                    end
                end else begin
                    n_res.found     = 1'b1;
                    n_res.pair_low  = pair_rdata[ID_W-1:0];
                    n_res.pair_high = pair_rdata[KEY_W-1:ID_W];
                    if (r_op == OP_WRITE_IDX) begin
                        value_we           = 1'b1;
                        n_res.result_value = r_val;
                    end else begin
                        n_res.result_value = value_rdata;
                    end
                    n_state = S_DONE;
                end
            end
            S_MISS: begin
                if (r_op == OP_ACCUM) begin
                    if (r_used < CW'(CAPACITY)) begin
                        // append at the tail
                        ram_waddr          = AW'(r_used);
                        pair_we            = 1'b1;
                        value_we           = 1'b1;
                        n_used             = r_used + CW'(1);
                        n_res.result_value = r_val;
                    end else begin
                        // drop the pair
                        n_res.status = ST_FULL;
                    end
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    n_out_word             = r_res;
                    n_out_word.entry_count = CNT_W'(r_used);
                    n_out_valid            = 1'b1;
                    n_state                = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_key      <= n_key;
        r_idx      <= n_idx;
        r_val      <= n_val;
        r_res      <= n_res;
        r_out_word <= n_out_word;
    end

    a_accept_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("word accepted without blocking the next one");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CW'(CAPACITY))
        else $error("entry count beyond capacity");

    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK) |-> (CW'(r_idx) < r_used))
        else $error("store read beyond the entries held");

endmodule
`default_nettype wire
